@@ rtl/nopc_pkg.sv @@
// Package for the non-overlapping pattern counter.
// Holds types, widths and register indexes that the counter modules share.
`default_nettype none

package nopc_pkg;

  localparam int unsigned PatBytes = 32;
  localparam int unsigned LenW     = 6;
  localparam int unsigned OutCntW  = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEN  = 3'd0,
    CFG_PAT0 = 3'd1,
    CFG_PAT1 = 3'd2,
    CFG_PAT2 = 3'd3,
    CFG_PAT3 = 3'd4
  } cfg_idx_e;

  typedef logic [PatBytes-1:0][7:0] pattern_t;

  typedef struct packed {
    logic            shift;
    logic [LenW-1:0] len;
  } cell_ctrl_t;

  typedef struct packed {
    logic               last;
    logic [OutCntW-1:0] count;
    logic               match;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/nopc_cell.sv @@
// One window cell: holds one text byte and compares the byte it takes in.
// Depends on nopc_pkg.
`default_nettype none

module nopc_cell #(
  parameter int unsigned POS = 0
) (
  input  wire logic                clk_i,
  input  wire nopc_pkg::cell_ctrl_t ctrl_i,
  input  wire nopc_pkg::pattern_t   pattern_i,
  input  wire logic [7:0]          byte_i,
  output logic [7:0]               byte_o,
  output logic                     match_o
);
  import nopc_pkg::*;

  logic [7:0]      byte_q;
  logic [LenW-1:0] pat_pos;
  logic            active;

  // The cell at distance POS from the newest byte faces pattern byte len-1-POS.
  assign pat_pos = ctrl_i.len - LenW'(POS) - LenW'(1);
  assign active  = LenW'(POS) < ctrl_i.len;
  assign match_o = !active || (byte_i == pattern_i[pat_pos[4:0]]);
  assign byte_o  = byte_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/nopc_window.sv @@
// Row of window cells that shifts one text byte per request.
// Depends on nopc_pkg and nopc_cell.
`default_nettype none

module nopc_window #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  wire logic                 clk_i,
  input  wire nopc_pkg::cell_ctrl_t ctrl_i,
  input  wire nopc_pkg::pattern_t   pattern_i,
  input  wire logic [7:0]           byte_i,
  output logic                      hit_o
);
  import nopc_pkg::*;

  logic [PATTERN_MAX:0][7:0]  chain;
  logic [PATTERN_MAX-1:0]     match;

  assign chain[0] = byte_i;

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    nopc_cell #(.POS(g)) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl_i),
      .pattern_i(pattern_i),
      .byte_i   (chain[g]),
      .byte_o   (chain[g+1]),
      .match_o  (match[g])
    );
  end

  assign hit_o = &match;

endmodule

`default_nettype wire

@@ rtl/nopc_skid.sv @@
// Two-entry output stage: an output register plus a skid register.
// Depends on nopc_pkg.
`default_nettype none

module nopc_skid (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire nopc_pkg::result_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output nopc_pkg::result_t      out_data_o
);
  import nopc_pkg::*;

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    in_fire;
  logic    out_fire;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_fire    = main_valid_q && out_ready_i;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (in_fire) begin
      if (!main_valid_q || out_ready_i) begin
        main_d       = in_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = in_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

@@ rtl/non_overlapping_pattern_counter_top.sv @@
// Top level of the non-overlapping pattern counter; depends on nopc_pkg,
// nopc_window, nopc_cell and nopc_skid.
// Throughput: one text byte per cycle while the skid register is empty; the window
// compare, fill counter and count all update in the cycle of the request.
// A result waits in the output register, or the skid one on a stall; two can wait.
// Reset: pattern length 1, pattern bytes zero, count and fill zero.
`default_nettype none

module non_overlapping_pattern_counter_top #(
  parameter int unsigned PATTERN_MAX = 32,
  parameter int unsigned COUNT_BITS  = 20
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [nopc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [nopc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,  // [7:0] text_byte
  input  wire logic                           s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [0] match_ends_here, [20:1] occurrence_count, [23:21] zero
  output logic [23:0]                         m_axis_tdata,
  output logic                                m_axis_tlast
);
  import nopc_pkg::*;

  logic [LenW-1:0]          len_q;
  logic [3:0][CfgDataW-1:0] pat_q;
  logic [LenW-1:0]          fill_q, fill_d;
  logic [COUNT_BITS-1:0]    count_q, count_d;
  logic [COUNT_BITS-1:0]    count_hit;
  logic [LenW-1:0]          len_eff;
  logic [LenW-1:0]          fill_inc;
  logic                     in_fire;
  logic                     window_hit;
  logic                     hit;
  cell_ctrl_t               cell_ctrl;
  pattern_t                 pattern;
  result_t                  result;
  result_t                  out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(1);
      pat_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEN:  len_q    <= cfg_data_i[LenW-1:0];
        CFG_PAT0: pat_q[0] <= cfg_data_i;
        CFG_PAT1: pat_q[1] <= cfg_data_i;
        CFG_PAT2: pat_q[2] <= cfg_data_i;
        CFG_PAT3: pat_q[3] <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  always_comb begin
    if (len_q == '0) begin
      len_eff = LenW'(1);
    end else if (len_q > LenW'(PATTERN_MAX)) begin
      len_eff = LenW'(PATTERN_MAX);
    end else begin
      len_eff = len_q;
    end
  end

  assign pattern         = pat_q;
  assign in_fire         = s_axis_tvalid && s_axis_tready;
  assign cell_ctrl.shift = in_fire;
  assign cell_ctrl.len   = len_eff;

  nopc_window #(.PATTERN_MAX(PATTERN_MAX)) u_window (
    .clk_i    (clk_i),
    .ctrl_i   (cell_ctrl),
    .pattern_i(pattern),
    .byte_i   (s_axis_tdata),
    .hit_o    (window_hit)
  );

  assign fill_inc  = (fill_q < LenW'(PATTERN_MAX)) ? fill_q + LenW'(1) : fill_q;
  assign hit       = window_hit && (fill_inc >= len_eff);
  assign count_hit = (hit && (count_q != '1)) ? count_q + COUNT_BITS'(1) : count_q;

  always_comb begin
    fill_d  = fill_q;
    count_d = count_q;
    if (in_fire) begin
      if (s_axis_tlast) begin
        fill_d  = '0;
        count_d = '0;
      end else begin
        fill_d  = hit ? '0 : fill_inc;
        count_d = count_hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      count_q <= '0;
    end else begin
      fill_q  <= fill_d;
      count_q <= count_d;
    end
  end

  assign result.match = hit;
  assign result.count = OutCntW'(count_hit);
  assign result.last  = s_axis_tlast;

  nopc_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (result),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_data)
  );

  assign m_axis_tdata = {3'b000, out_data.count, out_data.match};
  assign m_axis_tlast = out_data.last;

  a_ready_only_when_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |=> (count_q == '0) && (fill_q == '0))
    else $error("count or fill not cleared after end of text");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && s_axis_tlast) |=> count_q >= $past(count_q))
    else $error("count decreased within a text");

  a_hit_clears_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && hit) |=> fill_q == '0)
    else $error("fill not cleared after a counted match");

endmodule

`default_nettype wire

@@ test/non_overlapping_pattern_counter_top_tb.sv @@
// Testbench for non_overlapping_pattern_counter_top: streams text bytes under many pattern
// settings, predicts every match flag and running count, and checks each result.
// Depends on nopc_pkg and the counter RTL.
`default_nettype none

module non_overlapping_pattern_counter_top_tb;
  import nopc_pkg::*;

  localparam int unsigned CountBits      = 20;
  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned TextItems      = 1550;
  localparam int unsigned FirstUnusedIdx = int'(CFG_PAT3) + 1;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;
  logic                m_axis_tlast;

  // Predicted block state.
  logic [LenW-1:0]      len_reg   = LenW'(1);
  pattern_t             pat_bytes = '0;
  pattern_t             window    = '0;
  int unsigned          fill      = 0;
  logic [CountBits-1:0] total     = '0;

  result_t     match_reports_q[$];
  result_t     owed;
  int unsigned mismatches = 0;
  int unsigned sent       = 0;
  int unsigned burst_left = 0;
  int unsigned cycles     = 0;
  int unsigned rx_left    = 0;
  rx_mode_e    rx_mode    = RX_OPEN;

  non_overlapping_pattern_counter_top #(
    .PATTERN_MAX(PatBytes),
    .COUNT_BITS (CountBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic result_t count_text_byte(input logic [7:0] b, input logic last);
    int unsigned n;
    logic        hit;
    result_t     r;
    n = (len_reg == 0) ? 1 : ((len_reg > PatBytes) ? PatBytes : int'(len_reg));
    window = {window[PatBytes-2:0], b};
    if (fill < PatBytes) fill++;
    hit = (fill >= n);
    for (int k = 0; k < n; k++) begin
      if (window[n-1-k] != pat_bytes[k]) hit = 1'b0;
    end
    if (hit) begin
      if (total != '1) total++;
      fill = 0;
    end
    r.match = hit;
    r.count = OutCntW'(total);
    r.last  = last;
    if (last) begin
      total = '0;
      fill  = 0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_LEN: begin
        len_reg = data[LenW-1:0];
      end
      CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3: begin
        for (int j = 0; j < 8; j++) pat_bytes[8*(int'(idx)-1)+j] = data[8*j +: 8];
      end
      default: ;
    endcase
  endtask

  task automatic set_pattern(input logic [CfgDataW-1:0] len_word, input pattern_t pat);
    write_reg(CFG_LEN, len_word);
    for (int r = 0; r < 4; r++) write_reg(CfgIdxW'(int'(CFG_PAT0) + r), pat[8*r +: 8]);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    result_t     pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = count_text_byte(b, last);
    match_reports_q.insert(match_reports_q.size(), pred);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(20, 80);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 5);
      end
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (match_reports_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (match_reports_q.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        owed = match_reports_q.pop_front();
        if (m_axis_tdata[0] !== owed.match)
          report_mismatch($sformatf("match_ends_here %b, predicted %b",
                                    m_axis_tdata[0], owed.match));
        if (m_axis_tdata[OutCntW:1] !== owed.count)
          report_mismatch($sformatf("occurrence_count %0d, predicted %0d",
                                    m_axis_tdata[OutCntW:1], owed.count));
        if (m_axis_tlast !== owed.last)
          report_mismatch($sformatf("text_done %b, predicted %b", m_axis_tlast, owed.last));
      end
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 64);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready <= rx_left[2];
    endcase
  end

  task automatic test_reset_defaults();
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_greedy_overlap();
    set_pattern(64'd2, pattern_t'(64'h6161));
    for (int i = 0; i < 5; i++) push_byte(8'h61, i == 4);
    wait_idle();
  endtask

  task automatic test_zero_length();
    set_pattern(64'd0, pattern_t'(64'hFF));
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_unused_index();
    for (int idx = FirstUnusedIdx; idx < (1 << CfgIdxW); idx++)
      write_reg(CfgIdxW'(idx), '1);
    cfg_we_i <= 1'b0;
    push_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_midtext_reconfig();
    set_pattern(64'd3, pattern_t'(64'h636261));
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b0);
    wait_idle();
    set_pattern(64'd2, pattern_t'(64'h6362));
    push_byte(8'h63, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_stale_window();
    set_pattern(64'd2, pattern_t'(64'h7978));
    push_byte(8'h78, 1'b0);
    push_byte(8'h79, 1'b1);
    push_byte(8'h78, 1'b1);
    push_byte(8'h79, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_texts();
    int unsigned         roll;
    int unsigned         len_val;
    int unsigned         eff;
    int unsigned         cut;
    int unsigned         text_len;
    int unsigned         alpha_size;
    logic [7:0]          alpha_base;
    logic [7:0]          text_byte;
    logic                noisy;
    logic                ends_text;
    logic [CfgDataW-1:0] len_word;
    pattern_t            pat;
    logic [7:0]          text_q[$];
    while (sent < TextItems) begin
      roll = $urandom_range(0, 99);
      if (roll < 65) len_val = $urandom_range(1, 4);
      else if (roll < 85) len_val = $urandom_range(5, 31);
      else if (roll < 90) len_val = PatBytes;
      else if (roll < 94) len_val = 0;
      else len_val = $urandom_range(PatBytes + 1, (1 << LenW) - 1);
      eff = (len_val == 0) ? 1 : ((len_val > PatBytes) ? PatBytes : len_val);
      noisy      = ($urandom_range(0, 9) == 0);
      alpha_base = 8'($urandom_range(0, 255));
      alpha_size = $urandom_range(1, 3);
      for (int k = 0; k < PatBytes; k++) begin
        if (k < eff && !noisy) pat[k] = alpha_base + 8'($urandom_range(0, alpha_size - 1));
        else pat[k] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 19) == 0) pat = $urandom_range(0, 1) ? '1 : '0;
      len_word = {$urandom, $urandom};
      len_word[LenW-1:0] = LenW'(len_val);
      set_pattern(len_word, pat);

      text_q.delete();
      text_len = $urandom_range(1, 3 * eff + 12);
      while (text_q.size() < text_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          for (int k = 0; k < eff; k++) text_q.insert(text_q.size(), pat[k]);
        end else if (roll < 62 && eff > 1) begin
          cut = $urandom_range(1, eff - 1);
          for (int k = 0; k < cut; k++) text_q.insert(text_q.size(), pat[k]);
        end else if (roll < 92) begin
          text_byte = alpha_base + 8'($urandom_range(0, alpha_size - 1));
          text_q.insert(text_q.size(), text_byte);
        end else begin
          text_byte = 8'($urandom_range(0, 255));
          text_q.insert(text_q.size(), text_byte);
        end
      end
      ends_text = ($urandom_range(0, 99) < 85);
      foreach (text_q[i]) push_byte(text_q[i], ends_text && (i == text_q.size() - 1));
      wait_idle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_greedy_overlap();
    test_zero_length();
    test_unused_index();
    test_midtext_reconfig();
    test_stale_window();
    test_random_texts();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && match_reports_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/nopc_pkg.sv
rtl/nopc_cell.sv
rtl/nopc_window.sv
rtl/nopc_skid.sv
rtl/non_overlapping_pattern_counter_top.sv
test/non_overlapping_pattern_counter_top_tb.sv
